// ----- hw/rtl/clsf_pkg.sv -----
// Shared types, constants and solve microcode for the circle fit block.
package clsf_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PT_CAP     = (MAX_POINTS < 127) ? MAX_POINTS : 127;
  localparam int SW         = 128;  // width of the solve datapath
  localparam int BW         = 7;    // bit counter for SW iterations
  localparam int NSTEPS     = 16;

  typedef struct packed {
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic        last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] ctr_x;
    logic signed [23:0] ctr_y;
    logic [1:0]         fit_status;
  } out_word_t;

  typedef enum logic [1:0] {
    FS_OK    = 2'd0,
    FS_FEW   = 2'd1,
    FS_DEGEN = 2'd2
  } fit_status_t;

  typedef enum logic [4:0] {
    OP_N, OP_SX, OP_SY, OP_SXX, OP_SYY, OP_SXY, OP_RR, OP_EX, OP_HY,
    OP_C, OP_D, OP_G, OP_E, OP_H, OP_DEN, OP_NUMX, OP_NUMY
  } opnd_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    opnd_t dst;
    logic  first;  // clear the accumulator before this product
    logic  store;  // write the accumulator to dst after this product
  } step_t;

  // Each pair of steps forms dst = a0*b0 - a1*b1.
  function automatic step_t ucode(input logic [3:0] idx);
    step_t s;
    case (idx)
      4'd0:    s = '{OP_N,    OP_SXX, OP_C,    1'b1, 1'b0};
      4'd1:    s = '{OP_SX,   OP_SX,  OP_C,    1'b0, 1'b1};
      4'd2:    s = '{OP_N,    OP_SXY, OP_D,    1'b1, 1'b0};
      4'd3:    s = '{OP_SX,   OP_SY,  OP_D,    1'b0, 1'b1};
      4'd4:    s = '{OP_N,    OP_SYY, OP_G,    1'b1, 1'b0};
      4'd5:    s = '{OP_SY,   OP_SY,  OP_G,    1'b0, 1'b1};
      4'd6:    s = '{OP_EX,   OP_N,   OP_E,    1'b1, 1'b0};
      4'd7:    s = '{OP_RR,   OP_SX,  OP_E,    1'b0, 1'b1};
      4'd8:    s = '{OP_HY,   OP_N,   OP_H,    1'b1, 1'b0};
      4'd9:    s = '{OP_RR,   OP_SY,  OP_H,    1'b0, 1'b1};
      4'd10:   s = '{OP_C,    OP_G,   OP_DEN,  1'b1, 1'b0};
      4'd11:   s = '{OP_D,    OP_D,   OP_DEN,  1'b0, 1'b1};
      4'd12:   s = '{OP_E,    OP_G,   OP_NUMX, 1'b1, 1'b0};
      4'd13:   s = '{OP_H,    OP_D,   OP_NUMX, 1'b0, 1'b1};
      4'd14:   s = '{OP_H,    OP_C,   OP_NUMY, 1'b1, 1'b0};
      4'd15:   s = '{OP_E,    OP_D,   OP_NUMY, 1'b0, 1'b1};
      default: s = '{OP_N,    OP_N,   OP_C,    1'b1, 1'b0};
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/circle_least_squares_fit.sv -----
// Kasa circle fit: running sums per point, bit-serial exact solve on the last point.
// A point is registered in S_IDLE with its squares and cross product, then added to the sums in S_ACC.
// The last point adds a solve of 16 shift-add products, then two restoring divisions;
// with fewer than three points no solve runs, and a zero denominator skips the divisions.
// The output register holds a result while new points are already being taken.
// rst_n (synchronous) clears the count, all sums and the output valid.
module circle_least_squares_fit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  clsf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output clsf_pkg::out_word_t out_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ACC   = 7'b0000010,
    S_MLOAD = 7'b0000100,
    S_MRUN  = 7'b0001000,
    S_DLOAD = 7'b0010000,
    S_DRUN  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  localparam int SW = clsf_pkg::SW;

  state_t state_r;
  logic [6:0]  cnt_r;
  logic [22:0] sx_r, sy_r;
  logic [38:0] sxx_r, syy_r, sxy_r;
  logic [54:0] sx3_r, sy3_r, sxy2_r, sx2y_r;

  logic [15:0] x_r, y_r;
  logic [31:0] px2_r, py2_r, pxy_r;
  logic        last_r, take_r;

  logic [3:0]  step_r;
  logic [clsf_pkg::BW-1:0] bit_r;
  logic [SW-1:0] acc_r, p_r, q_r;
  logic [SW-1:0] c_r, d_r, g_r, e_r, h_r, den_r, numx_r, numy_r;

  logic          sel_r, neg_r;
  logic [SW-1:0] dvd_r, dvs_r;
  logic [SW:0]   rem_r;

  logic [23:0] cx_r, cy_r;
  logic [1:0]  stat_r;
  logic        out_valid_r;
  clsf_pkg::out_word_t out_data_r;

  clsf_pkg::step_t st;
  logic [SW-1:0] opa, opb, acc_nxt, addend;
  logic [SW-1:0] num, an, ad, dvd_nxt, qsat_in;
  logic [SW:0]   rem_sh, rem_nxt;
  logic          ge, last_bit;
  logic [6:0]    cnt_nxt;
  logic [23:0]   sat_nxt;
  logic          out_free;

  function automatic logic [SW-1:0] pick(input clsf_pkg::opnd_t s,
      input logic [6:0] n, input logic [22:0] sx, input logic [22:0] sy,
      input logic [38:0] sxx, input logic [38:0] syy, input logic [38:0] sxy,
      input logic [55:0] ex, input logic [55:0] hy,
      input logic [SW-1:0] c, input logic [SW-1:0] d, input logic [SW-1:0] g,
      input logic [SW-1:0] e, input logic [SW-1:0] h);
    logic [SW-1:0] v;
    case (s)
      clsf_pkg::OP_N:   v = SW'(n);
      clsf_pkg::OP_SX:  v = SW'(sx);
      clsf_pkg::OP_SY:  v = SW'(sy);
      clsf_pkg::OP_SXX: v = SW'(sxx);
      clsf_pkg::OP_SYY: v = SW'(syy);
      clsf_pkg::OP_SXY: v = SW'(sxy);
      clsf_pkg::OP_RR:  v = SW'({1'b0, sxx} + {1'b0, syy});
      clsf_pkg::OP_EX:  v = SW'(ex);
      clsf_pkg::OP_HY:  v = SW'(hy);
      clsf_pkg::OP_C:   v = c;
      clsf_pkg::OP_D:   v = d;
      clsf_pkg::OP_G:   v = g;
      clsf_pkg::OP_E:   v = e;
      clsf_pkg::OP_H:   v = h;
      default:          v = '0;
    endcase
    return v;
  endfunction

  logic [55:0] ex_sum, hy_sum;

  always_comb begin
    st      = clsf_pkg::ucode(step_r);
    ex_sum  = {1'b0, sx3_r} + {1'b0, sxy2_r};
    hy_sum  = {1'b0, sx2y_r} + {1'b0, sy3_r};
    opa     = pick(st.a, cnt_r, sx_r, sy_r, sxx_r, syy_r, sxy_r, ex_sum, hy_sum,
                   c_r, d_r, g_r, e_r, h_r);
    opb     = pick(st.b, cnt_r, sx_r, sy_r, sxx_r, syy_r, sxy_r, ex_sum, hy_sum,
                   c_r, d_r, g_r, e_r, h_r);
    // The second product of a pair is subtracted from the first.
    addend  = q_r[0] ? (st.first ? p_r : (~p_r + SW'(1))) : '0;
    acc_nxt = acc_r + addend;
    last_bit = (bit_r == clsf_pkg::BW'(SW - 1));

    num = sel_r ? numy_r : numx_r;
    an  = num[SW-1] ? (~num + SW'(1)) : num;
    ad  = den_r[SW-1] ? (~den_r + SW'(1)) : den_r;

    rem_sh  = {rem_r[SW-1:0], dvd_r[SW-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
    dvd_nxt = {dvd_r[SW-2:0], ge};

    // Saturate the quotient magnitude and apply the sign.
    qsat_in = dvd_nxt;
    if (neg_r) begin
      if ((|qsat_in[SW-1:24]) || (qsat_in[23:0] > 24'd8388608)) begin
        sat_nxt = 24'h800000;
      end else begin
        sat_nxt = ~qsat_in[23:0] + 24'd1;
      end
    end else begin
      if ((|qsat_in[SW-1:24]) || qsat_in[23]) begin
        sat_nxt = 24'h7FFFFF;
      end else begin
        sat_nxt = qsat_in[23:0];
      end
    end

    cnt_nxt  = take_r ? (cnt_r + 7'd1) : cnt_r;
    out_free = !out_valid_r || out_ready;
  end

  // Control state and running sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sx_r   <= '0; sy_r   <= '0;
      sxx_r  <= '0; syy_r  <= '0; sxy_r <= '0;
      sx3_r  <= '0; sy3_r  <= '0; sxy2_r <= '0; sx2y_r <= '0;
      step_r <= '0;
      bit_r  <= '0;
      sel_r  <= 1'b0;
    end else begin
      // In S_OUT the valid flag is handled by the state itself.
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (take_r) begin
            sx_r   <= sx_r + 23'(x_r);
            sy_r   <= sy_r + 23'(y_r);
            sxx_r  <= sxx_r + 39'(px2_r);
            syy_r  <= syy_r + 39'(py2_r);
            sxy_r  <= sxy_r + 39'(pxy_r);
            sx3_r  <= sx3_r + 55'(px2_r) * 55'(x_r);
            sy3_r  <= sy3_r + 55'(py2_r) * 55'(y_r);
            sxy2_r <= sxy2_r + 55'(py2_r) * 55'(x_r);
            sx2y_r <= sx2y_r + 55'(px2_r) * 55'(y_r);
          end
          cnt_r <= cnt_nxt;
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (cnt_nxt < 7'd3) begin
            state_r <= S_OUT;
          end else begin
            step_r  <= '0;
            state_r <= S_MLOAD;
          end
        end
        S_MLOAD: begin
          bit_r   <= '0;
          state_r <= S_MRUN;
        end
        S_MRUN: begin
          bit_r <= bit_r + clsf_pkg::BW'(1);
          if (last_bit) begin
            if (step_r == 4'(clsf_pkg::NSTEPS - 1)) begin
              if (den_r == '0) begin
                state_r <= S_OUT;
              end else begin
                sel_r   <= 1'b0;
                state_r <= S_DLOAD;
              end
            end else begin
              step_r  <= step_r + 4'd1;
              state_r <= S_MLOAD;
            end
          end
        end
        S_DLOAD: begin
          bit_r   <= '0;
          state_r <= S_DRUN;
        end
        S_DRUN: begin
          bit_r <= bit_r + clsf_pkg::BW'(1);
          if (last_bit) begin
            if (!sel_r) begin
              sel_r   <= 1'b1;
              state_r <= S_DLOAD;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            cnt_r  <= '0;
            sx_r   <= '0; sy_r   <= '0;
            sxx_r  <= '0; syy_r  <= '0; sxy_r <= '0;
            sx3_r  <= '0; sy3_r  <= '0; sxy2_r <= '0; sx2y_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r    <= in_data.x_coord;
        y_r    <= in_data.y_coord;
        last_r <= in_data.last_point;
        take_r <= (cnt_r < 7'(clsf_pkg::PT_CAP));
        px2_r  <= in_data.x_coord * in_data.x_coord;
        py2_r  <= in_data.y_coord * in_data.y_coord;
        pxy_r  <= in_data.x_coord * in_data.y_coord;
      end
      S_ACC: begin
        stat_r <= clsf_pkg::FS_FEW;
        cx_r   <= '0;
        cy_r   <= '0;
      end
      S_MLOAD: begin
        p_r <= opa;
        q_r <= opb;
        if (st.first) begin
          acc_r <= '0;
        end
      end
      S_MRUN: begin
        acc_r <= acc_nxt;
        p_r   <= {p_r[SW-2:0], 1'b0};
        q_r   <= {1'b0, q_r[SW-1:1]};
        if (last_bit) begin
          stat_r <= clsf_pkg::FS_DEGEN;
          if (st.store) begin
            case (st.dst)
              clsf_pkg::OP_C:    c_r    <= acc_nxt;
              clsf_pkg::OP_D:    d_r    <= acc_nxt;
              clsf_pkg::OP_G:    g_r    <= acc_nxt;
              clsf_pkg::OP_E:    e_r    <= acc_nxt;
              clsf_pkg::OP_H:    h_r    <= acc_nxt;
              clsf_pkg::OP_DEN:  den_r  <= acc_nxt;
              clsf_pkg::OP_NUMX: numx_r <= acc_nxt;
              clsf_pkg::OP_NUMY: numy_r <= acc_nxt;
              default: ;
            endcase
          end
        end
      end
      S_DLOAD: begin
        dvd_r <= an + ad;
        dvs_r <= {ad[SW-2:0], 1'b0};
        rem_r <= '0;
        neg_r <= num[SW-1] ^ den_r[SW-1];
      end
      S_DRUN: begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_nxt;
        if (last_bit) begin
          stat_r <= clsf_pkg::FS_OK;
          if (sel_r) begin
            cy_r <= sat_nxt;
          end else begin
            cx_r <= sat_nxt;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_data_r.ctr_x      <= cx_r;
          out_data_r.ctr_y      <= cy_r;
          out_data_r.fit_status <= stat_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/clsf_checker.sv -----
// Port-level checks for the circle fit block, bound to the top level.
module clsf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input clsf_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input clsf_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fit_status <= clsf_pkg::FS_DEGEN)
    else $error("undefined fit status");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fit_status != clsf_pkg::FS_OK |->
      out_data.ctr_x == 24'sd0 && out_data.ctr_y == 24'sd0)
    else $error("failed fit with nonzero centre");

  // A point that does not close the set never starts a result.
  a_no_result_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.last_point |=> !$rose(out_valid))
    else $error("result without a last point");

endmodule

bind circle_least_squares_fit clsf_checker u_clsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
